@@ sv/sfr_pkg.sv @@
// Shared types, constants and sizes for the stuffed frame receiver.
package sfr_pkg;

    // Payload limit and the widths that follow from it
    localparam int MAX_PAYLOAD = 256;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int LEN_W       = 9;

    // Queue sizes
    localparam int OP_DEPTH   = 4;
    localparam int OP_PTR_W   = $clog2(OP_DEPTH);
    localparam int OP_CNT_W   = $clog2(OP_DEPTH + 1);
    localparam int RES_DEPTH  = 2;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    // Line codes
    localparam logic [7:0] FLAG_BYTE     = 8'h7E;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] ESC_FLAG      = 8'h5E;
    localparam logic [7:0] ESC_ESC       = 8'h5D;
    localparam logic [7:0] CTRL_I0       = 8'h00;
    localparam logic [7:0] CTRL_I1       = 8'h40;
    localparam logic [6:0] RR_BITS       = 7'h05;
    localparam logic [6:0] REJ_BITS      = 7'h01;
    localparam logic [7:0] RESET_ADDRESS = 8'h03;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_DATA,
        PH_ESC
    } phase_t;

    // Commands from the parser to the frame engine
    typedef enum logic [1:0] {
        OP_START,
        OP_DATA,
        OP_END
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
        logic       aborted;
    } op_t;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             frame_end;
        logic             frame_good;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       reply_control;
    } result_t;

endpackage

@@ sv/sfr_front.sv @@
// Frame parser: hunts for flags, checks the header, unstuffs and issues commands.
module sfr_front
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       accept,
    input  logic [7:0] line_byte,
    output logic       op_valid,
    output op_t        op
);

    phase_t     phase_reg, phase_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [7:0] addr_reg;

    assign cfg_ready = 1'b1;

    // Address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= RESET_ADDRESS;
        end
        else if (cfg_valid)
        begin
            addr_reg <= cfg_data;
        end
    end

    // Phase and control byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            ctrl_reg  <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    // Next phase and command
    always_comb
    begin
        phase_next = phase_reg;
        ctrl_next  = ctrl_reg;
        op_valid   = 1'b0;
        op.kind    = OP_DATA;
        op.data    = line_byte;
        op.aborted = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_FLAG:
                begin
                    if (line_byte == addr_reg)
                        phase_next = PH_ADDR;
                    else if (line_byte != FLAG_BYTE)
                        phase_next = PH_HUNT;
                end
                PH_ADDR:
                begin
                    if (line_byte == CTRL_I0 || line_byte == CTRL_I1)
                    begin
                        ctrl_next  = line_byte;
                        phase_next = PH_CTRL;
                    end
                    else
                    begin
                        phase_next = (line_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                    end
                end
                PH_CTRL:
                begin
                    if (line_byte == (addr_reg ^ ctrl_reg))
                    begin
                        op_valid   = 1'b1;
                        op.kind    = OP_START;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = (line_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if (line_byte == ESC_BYTE)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (line_byte == FLAG_BYTE)
                    begin
                        op_valid   = 1'b1;
                        op.kind    = OP_END;
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        op_valid = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    if (line_byte == FLAG_BYTE)
                    begin
                        // flag right after escape aborts the frame
                        op_valid   = 1'b1;
                        op.kind    = OP_END;
                        op.aborted = 1'b1;
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        if (line_byte == ESC_FLAG)
                        begin
                            op_valid = 1'b1;
                            op.data  = FLAG_BYTE;
                        end
                        else if (line_byte == ESC_ESC)
                        begin
                            op_valid = 1'b1;
                            op.data  = ESC_BYTE;
                        end
                        // unknown escape: both bytes dropped
                    end
                end
                PH_HUNT:
                begin
                    phase_next = (line_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

endmodule

@@ sv/sfr_op_queue.sv @@
// Short command queue between the parser and the frame engine.
module sfr_op_queue
    import sfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output op_t  head_op,
    output logic empty
);

    op_t                 mem_reg [OP_DEPTH];
    logic [OP_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OP_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == OP_CNT_W'(OP_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == OP_PTR_W'(OP_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == OP_PTR_W'(OP_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= OP_CNT_W'(OP_DEPTH))
        else $error("op queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("op queue count did not grow on push");

endmodule

@@ sv/sfr_back.sv @@
// Frame engine: holds the last byte back, tracks check and length, queues results.
module sfr_back
    import sfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_empty,
    input  op_t              op,
    output logic             op_pop,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       payload_byte,
    output logic             frame_end,
    output logic             frame_good,
    output logic [LEN_W-1:0] payload_length,
    output logic [7:0]       reply_control
);

    logic [7:0]       held_byte_reg, held_byte_next;
    logic             held_valid_reg, held_valid_next;
    logic [7:0]       xor_reg, xor_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             seq_reg, seq_next;

    result_t              res_mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_reg, res_rd_reg;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                 res_push, res_pop, res_space;
    result_t              res_wr;
    logic                 good;

    // Result buffer handshake
    assign empty     = (res_cnt_reg == '0);
    assign res_pop   = pop && !empty;
    assign res_space = (res_cnt_reg != RES_CNT_W'(RES_DEPTH)) || res_pop;
    assign op_pop    = !op_empty && res_space;

    assign good = !op.aborted && held_valid_reg && (count_reg != '0) && !ovf_reg
                  && (xor_reg == held_byte_reg);

    // Execute one command
    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        xor_next        = xor_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        seq_next        = seq_reg;
        res_push        = 1'b0;
        res_wr          = '0;
        if (op_pop)
        begin
            unique case (op.kind)
                OP_START:
                begin
                    held_byte_next  = 8'h00;
                    held_valid_next = 1'b0;
                    xor_next        = 8'h00;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                end
                OP_DATA:
                begin
                    if (held_valid_reg)
                    begin
                        if (count_reg < CNT_W'(MAX_PAYLOAD))
                        begin
                            res_push            = 1'b1;
                            res_wr.payload_byte = held_byte_reg;
                            xor_next            = xor_reg ^ held_byte_reg;
                            count_next          = count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    held_byte_next  = op.data;
                    held_valid_next = 1'b1;
                end
                OP_END:
                begin
                    res_push              = 1'b1;
                    res_wr.frame_end      = 1'b1;
                    res_wr.frame_good     = good;
                    res_wr.payload_length = LEN_W'(count_reg);
                    res_wr.reply_control  = {seq_reg, good ? RR_BITS : REJ_BITS};
                    if (good)
                        seq_next = !seq_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result count
    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (res_push && !res_pop)
            res_cnt_next = res_cnt_reg + 1'b1;
        else if (res_pop && !res_push)
            res_cnt_next = res_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            xor_reg        <= 8'h00;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            seq_reg        <= 1'b1;
            res_wr_reg     <= '0;
            res_rd_reg     <= '0;
            res_cnt_reg    <= '0;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            xor_reg        <= xor_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            seq_reg        <= seq_next;
            res_cnt_reg    <= res_cnt_next;
            if (res_push)
                res_wr_reg <= (res_wr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0
                              : res_wr_reg + 1'b1;
            if (res_pop)
                res_rd_reg <= (res_rd_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0
                              : res_rd_reg + 1'b1;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (res_push)
            res_mem_reg[res_wr_reg] <= res_wr;
    end

    assign payload_byte   = res_mem_reg[res_rd_reg].payload_byte;
    assign frame_end      = res_mem_reg[res_rd_reg].frame_end;
    assign frame_good     = res_mem_reg[res_rd_reg].frame_good;
    assign payload_length = res_mem_reg[res_rd_reg].payload_length;
    assign reply_control  = res_mem_reg[res_rd_reg].reply_control;

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result buffer overfilled");

    a_seq_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_wr.frame_end && res_wr.frame_good) |=> seq_reg != $past(seq_reg))
        else $error("sequence bit did not toggle after good frame");

    a_seq_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_wr.frame_end && !res_wr.frame_good) |=> seq_reg == $past(seq_reg))
        else $error("sequence bit changed after bad frame");

endmodule

@@ sv/stuffed_frame_receiver.sv @@
// A result, if any, passes the command queue and the result buffer to the ports.
// Payload bytes come out one byte late: each is released by the next unstuffed byte.
// Throughput: one line byte per cycle, sustained while the result side keeps up.
// A four-entry command queue and a two-entry result buffer decouple the two sides.
// Reset (rst_n low, asynchronous) empties both queues, hunts for a flag, address = 3.
module stuffed_frame_receiver
    import sfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       line_byte,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       payload_byte,
    output logic             frame_end,
    output logic             frame_good,
    output logic [LEN_W-1:0] payload_length,
    output logic [7:0]       reply_control,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data
);

    logic accept;
    logic op_valid;
    op_t  op_in;
    op_t  op_head;
    logic op_empty;
    logic op_pop;

    assign accept = push && !full;

    // Parser
    sfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .line_byte (line_byte),
        .op_valid  (op_valid),
        .op        (op_in)
    );

    // Command queue
    sfr_op_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (op_valid),
        .push_op (op_in),
        .full    (full),
        .pop     (op_pop),
        .head_op (op_head),
        .empty   (op_empty)
    );

    // Frame engine
    sfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .op_empty       (op_empty),
        .op             (op_head),
        .op_pop         (op_pop),
        .pop            (pop),
        .empty          (empty),
        .payload_byte   (payload_byte),
        .frame_end      (frame_end),
        .frame_good     (frame_good),
        .payload_length (payload_length),
        .reply_control  (reply_control)
    );

endmodule
